// ----- src/gdo_pkg.sv -----
// ----------------------------------------------------------------------------
// gdo_pkg
// Shared types, constants and calendar functions for the date offset unit.
// ----------------------------------------------------------------------------
package gdo_pkg;

  localparam int DAY_W        = 5;
  localparam int MONTH_W      = 4;
  localparam int YEAR_W       = 14;
  localparam int COUNT_W      = 16;
  // walked year, signed, wide enough for the start year plus or minus the walk
  localparam int YEAR_VAL_W   = 16;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 24;

  localparam int OFFSET_BITS_DEF = 16;

  localparam int YEAR_MIN     = 1582;
  localparam int YEAR_MAX     = 9999;
  localparam int YEAR_CYCLE   = 400;
  localparam int CENTURY      = 100;
  localparam int MONTHS       = 12;
  localparam int FEB_LEAP     = 29;
  localparam int LAST_DAY     = 31;

  // mod-400 reduction of a 14-bit year: subtract 400 << k for k = 5 down to 0
  localparam int REDUCE_STEPS = 6;
  localparam int SHIFT_W      = $clog2(REDUCE_STEPS);

  localparam logic [DAY_W-1:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CLAMP,
    ST_OFFSET,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_LOAD,
    STEP_REDUCE,
    STEP_CLAMP,
    STEP_OFFSET,
    STEP_WALK,
    STEP_OUT
  } step_t;

  typedef struct packed {
    step_t              step;
    logic [SHIFT_W-1:0] shift;
  } ctrl_t;

  // r is the year modulo 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] r);
    logic leap;
    leap = (r[1:0] == 2'b00) && (r != YEAR_W'(CENTURY)) &&
           (r != YEAR_W'(2 * CENTURY)) && (r != YEAR_W'(3 * CENTURY));
    return leap;
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] len;
    len = DAY_W'(LAST_DAY);
    if (m >= MONTH_W'(1) && m <= MONTH_W'(MONTHS)) begin
      len = MONTH_LEN[m];
    end
    if (m == MONTH_W'(2) && leap) begin
      len = DAY_W'(FEB_LEAP);
    end
    return len;
  endfunction

endpackage

// ----- src/gdo_datapath.sv -----
// ----------------------------------------------------------------------------
// gdo_datapath
// Date registers, the shared day adder and the month/year counters.
// ----------------------------------------------------------------------------
module gdo_datapath #(
  parameter int OFFSET_BITS = gdo_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  gdo_pkg::ctrl_t               ctrl,
  input  logic                         operation,
  input  logic [gdo_pkg::DAY_W-1:0]    start_day,
  input  logic [gdo_pkg::MONTH_W-1:0]  start_month,
  input  logic [gdo_pkg::YEAR_W-1:0]   start_year,
  input  logic [gdo_pkg::COUNT_W-1:0]  day_count,
  output logic                         walk_more,
  output logic [gdo_pkg::DAY_W-1:0]    result_day,
  output logic [gdo_pkg::MONTH_W-1:0]  result_month,
  output logic [gdo_pkg::YEAR_W-1:0]   result_year,
  output logic                         out_of_range
);
  import gdo_pkg::*;

  localparam int NB = (OFFSET_BITS < COUNT_W) ? OFFSET_BITS : COUNT_W;
  localparam int DW = NB + 2;

  logic                  op;
  logic [DW-1:0]         d;
  logic [MONTH_W-1:0]    m;
  logic [YEAR_VAL_W-1:0] y;
  logic [YEAR_W-1:0]     r;
  logic [NB-1:0]         n;

  logic                  leap;
  logic [DAY_W-1:0]      len_cur;
  logic [DAY_W-1:0]      len_prev;
  logic [MONTH_W-1:0]    m_prev;
  logic [DW-1:0]         operand;
  logic                  negate;
  logic [DW-1:0]         sum;
  logic                  sum_pos;
  logic                  d_nonpos;
  logic [YEAR_W-1:0]     reduce_val;
  logic                  below_min;
  logic                  above_max;

  always_comb begin
    leap     = is_leap(r);
    len_cur  = days_in_month(m, leap);
    // stepping back from january lands on december, 31 days whatever the year
    m_prev   = (m == MONTH_W'(1)) ? MONTH_W'(MONTHS) : m - MONTH_W'(1);
    len_prev = days_in_month(m_prev, leap);

    operand = '0;
    negate  = 1'b0;
    case (ctrl.step)
      STEP_CLAMP: begin
        operand = DW'(len_cur);
        negate  = 1'b1;
      end
      STEP_OFFSET: begin
        operand = DW'(n);
        negate  = op;
      end
      STEP_WALK: begin
        operand = op ? DW'(len_prev) : DW'(len_cur);
        negate  = ~op;
      end
      default: begin
        operand = '0;
        negate  = 1'b0;
      end
    endcase

    // shared adder, d is two's complement
    sum      = d + (negate ? ~operand : operand) + DW'(negate);
    sum_pos  = !sum[DW-1] && (sum != '0);
    d_nonpos = d[DW-1] || (d == '0);
    walk_more = op ? d_nonpos : sum_pos;

    reduce_val = YEAR_W'(YEAR_CYCLE) << ctrl.shift;

    below_min = $signed(y) < $signed(YEAR_VAL_W'(YEAR_MIN));
    above_max = $signed(y) > $signed(YEAR_VAL_W'(YEAR_MAX));
  end

  always_ff @(posedge clk) begin
    case (ctrl.step)
      STEP_LOAD: begin
        op <= operation;
        d  <= (start_day == '0) ? DW'(1) : DW'(start_day);
        if (start_month == '0) begin
          m <= MONTH_W'(1);
        end else if (start_month > MONTH_W'(MONTHS)) begin
          m <= MONTH_W'(MONTHS);
        end else begin
          m <= start_month;
        end
        y <= YEAR_VAL_W'(start_year);
        r <= start_year;
        n <= day_count[NB-1:0];
      end
      STEP_REDUCE: begin
        if (r >= reduce_val) begin
          r <= r - reduce_val;
        end
      end
      STEP_CLAMP: begin
        if (sum_pos) begin
          d <= DW'(len_cur);
        end
      end
      STEP_OFFSET: begin
        d <= sum;
      end
      STEP_WALK: begin
        if (walk_more) begin
          d <= sum;
          if (!op) begin
            if (m == MONTH_W'(MONTHS)) begin
              m <= MONTH_W'(1);
              y <= y + YEAR_VAL_W'(1);
              r <= (r == YEAR_W'(YEAR_CYCLE - 1)) ? '0 : r + YEAR_W'(1);
            end else begin
              m <= m + MONTH_W'(1);
            end
          end else begin
            m <= m_prev;
            if (m == MONTH_W'(1)) begin
              y <= y - YEAR_VAL_W'(1);
              r <= (r == '0) ? YEAR_W'(YEAR_CYCLE - 1) : r - YEAR_W'(1);
            end
          end
        end
      end
      STEP_OUT: begin
        if (below_min) begin
          result_day   <= DAY_W'(1);
          result_month <= MONTH_W'(1);
          result_year  <= YEAR_W'(YEAR_MIN);
          out_of_range <= 1'b1;
        end else if (above_max) begin
          result_day   <= DAY_W'(LAST_DAY);
          result_month <= MONTH_W'(MONTHS);
          result_year  <= YEAR_W'(YEAR_MAX);
          out_of_range <= 1'b1;
        end else begin
          result_day   <= d[DAY_W-1:0];
          result_month <= m;
          result_year  <= y[YEAR_W-1:0];
          out_of_range <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/gdo_ctrl.sv -----
// ----------------------------------------------------------------------------
// gdo_ctrl
// Sequencer: load, mod-400 reduction, day clamp, offset, month walk, output.
// ----------------------------------------------------------------------------
module gdo_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic           walk_more,
  output gdo_pkg::ctrl_t ctrl
);
  import gdo_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [SHIFT_W-1:0] shift;
  logic [SHIFT_W-1:0] shift_next;
  logic               out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      shift     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      shift     <= shift_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    shift_next = shift;
    ctrl.step  = STEP_NONE;
    ctrl.shift = shift;
    in_ready   = 1'b0;
    out_valid_next = out_ready ? 1'b0 : out_valid;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.step  = STEP_LOAD;
          shift_next = SHIFT_W'(REDUCE_STEPS - 1);
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        ctrl.step = STEP_REDUCE;
        if (shift == '0) begin
          state_next = ST_CLAMP;
        end else begin
          shift_next = shift - SHIFT_W'(1);
        end
      end
      ST_CLAMP: begin
        ctrl.step  = STEP_CLAMP;
        state_next = ST_OFFSET;
      end
      ST_OFFSET: begin
        ctrl.step  = STEP_OFFSET;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        ctrl.step = STEP_WALK;
        if (!walk_more) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the output register to drain
        if (!out_valid || out_ready) begin
          ctrl.step      = STEP_OUT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/gregorian_date_offset_unit.sv -----
// the month walk steps one month per cycle through the shared day adder, up to
// about 2150 months walked for a 16-bit day count. one item at a time: the next
// input beat is taken once the result is in the output register, which holds it
// until taken. rst (synchronous) clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// gregorian_date_offset_unit
// Adds or subtracts a day count to a Gregorian date, walking month by month.
// ----------------------------------------------------------------------------
module gregorian_date_offset_unit #(
  parameter int OFFSET_BITS = gdo_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_day[4:0], start_month[8:5], start_year[22:9], day_count[38:23], pad
  input  logic [gdo_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation[0]
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // result_day[4:0], result_month[8:5], result_year[22:9], pad
  output logic [gdo_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // out_of_range[0]
  output logic [0:0]                      m_axis_tuser
);
  import gdo_pkg::*;

  ctrl_t              ctrl;
  logic               walk_more;
  logic [DAY_W-1:0]   result_day;
  logic [MONTH_W-1:0] result_month;
  logic [YEAR_W-1:0]  result_year;
  logic               out_of_range;

  gdo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .walk_more (walk_more),
    .ctrl      (ctrl)
  );

  gdo_datapath #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk          (clk),
    .ctrl         (ctrl),
    .operation    (s_axis_tuser[0]),
    .start_day    (s_axis_tdata[4:0]),
    .start_month  (s_axis_tdata[8:5]),
    .start_year   (s_axis_tdata[22:9]),
    .day_count    (s_axis_tdata[38:23]),
    .walk_more    (walk_more),
    .result_day   (result_day),
    .result_month (result_month),
    .result_year  (result_year),
    .out_of_range (out_of_range)
  );

  assign m_axis_tdata = {1'b0, result_year, result_month, result_day};
  assign m_axis_tuser = out_of_range;

endmodule

// ----- src/gdo_checker.sv -----
// ----------------------------------------------------------------------------
// gdo_checker
// Port-level checks on the date offset unit, bound to the top level.
// ----------------------------------------------------------------------------
module gdo_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [gdo_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [0:0]                      m_axis_tuser
);
  import gdo_pkg::*;

  // a stalled result beat stays up
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // one item at a time: after an input beat the block is busy
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while walking");

  // a range flag comes with one of the two clamp dates
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[22:9] == 14'(YEAR_MIN) && m_axis_tdata[8:5] == 4'd1 &&
       m_axis_tdata[4:0] == 5'd1) ||
      (m_axis_tdata[22:9] == 14'(YEAR_MAX) && m_axis_tdata[8:5] == 4'(MONTHS) &&
       m_axis_tdata[4:0] == 5'(LAST_DAY)))
    else $error("range flag without clamp date");

  // every result is a date in range
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      m_axis_tdata[22:9] >= 14'(YEAR_MIN) && m_axis_tdata[22:9] <= 14'(YEAR_MAX) &&
      m_axis_tdata[8:5] >= 4'd1 && m_axis_tdata[8:5] <= 4'(MONTHS) &&
      m_axis_tdata[4:0] >= 5'd1)
    else $error("result date out of range");

endmodule

bind gregorian_date_offset_unit gdo_checker u_gdo_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/gregorian_date_offset_unit_test.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_offset_unit_test
// Self-checking bench for the date offset unit. Each date/offset beat sent to
// the unit is run through an in-bench calendar walk and the predicted date is
// queued. Every result beat is compared field by field against the oldest
// prediction. Stimulus: directed calendar corners, then random well-formed
// dates and raw noise, random stalls on both streams, then a stall-free run.
// ----------------------------------------------------------------------------
module gregorian_date_offset_unit_test;
  import gdo_pkg::*;

  localparam int  OFFSET_BITS = OFFSET_BITS_DEF;
  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_SUB     = 1'b1;

  typedef struct packed {
    logic               op;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [COUNT_W-1:0] count;
  } date_item_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               oor;
  } date_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  date_result_t pending_dates[$];
  bit idle_on = 1'b1;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int flagged_results = 0;
  int ready_stall_left = 0;

  gregorian_date_offset_unit #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // ---- calendar prediction ----
  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % CENTURY != 0)) || (y % YEAR_CYCLE == 0);
  endfunction

  function automatic int month_days(input int m, input int y);
    int lengths [13];
    lengths = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > MONTHS) return LAST_DAY;
    if (m == 2 && leap_year(y)) return FEB_LEAP;
    return lengths[m];
  endfunction

  function automatic date_result_t predict_offset(input date_item_t it);
    int d;
    int m;
    int y;
    int n;
    date_result_t r;
    m = int'(it.month);
    y = int'(it.year);
    n = int'(it.count) & ((1 << OFFSET_BITS) - 1);
    if (m < 1) m = 1;
    if (m > MONTHS) m = MONTHS;
    d = int'(it.day);
    if (d < 1) d = 1;
    if (d > month_days(m, y)) d = month_days(m, y);
    if (it.op == OP_ADD) begin
      d += n;
      while (d > month_days(m, y)) begin
        d -= month_days(m, y);
        m += 1;
        if (m > MONTHS) begin
          m = 1;
          y += 1;
        end
      end
    end else begin
      d -= n;
      // step back first, then add the length of the month stepped into
      while (d < 1) begin
        m -= 1;
        if (m < 1) begin
          m = MONTHS;
          y -= 1;
        end
        d += month_days(m, y);
      end
    end
    r.oor = 1'b0;
    if (y < YEAR_MIN) begin
      d = 1; m = 1; y = YEAR_MIN; r.oor = 1'b1;
    end else if (y > YEAR_MAX) begin
      d = LAST_DAY; m = MONTHS; y = YEAR_MAX; r.oor = 1'b1;
    end
    r.day   = d[DAY_W-1:0];
    r.month = m[MONTH_W-1:0];
    r.year  = y[YEAR_W-1:0];
    return r;
  endfunction

  // ---- stimulus helpers ----
  function automatic date_item_t make_item(input logic op, input int d, input int m,
                                           input int y, input int n);
    date_item_t it;
    it.op    = op;
    it.day   = d[DAY_W-1:0];
    it.month = m[MONTH_W-1:0];
    it.year  = y[YEAR_W-1:0];
    it.count = n[COUNT_W-1:0];
    return it;
  endfunction

  // mostly short offsets so the month walk stays quick, a few full-range
  function automatic int rand_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 60);
      6, 7:             return $urandom_range(0, 1500);
      8:                return $urandom_range(0, 65535);
      default:          return $urandom_range(60000, 65535);
    endcase
  endfunction

  function automatic date_item_t rand_valid_item();
    int y;
    int m;
    case ($urandom_range(0, 7))
      0:       y = $urandom_range(YEAR_MIN, YEAR_MIN + 20);
      1:       y = $urandom_range(YEAR_MAX - 20, YEAR_MAX);
      default: y = $urandom_range(YEAR_MIN, YEAR_MAX);
    endcase
    m = $urandom_range(1, MONTHS);
    return make_item(logic'($urandom_range(0, 1)), $urandom_range(1, month_days(m, y)),
                     m, y, rand_count());
  endfunction

  task automatic send_date(input date_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.count, it.year, it.month, it.day};
    s_axis_tuser  <= it.op;
    do @(posedge clk); while (!s_axis_tready);
    pending_dates.push_back(predict_offset(it));
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // ---- tests ----
  task automatic test_calendar_corners();
    send_date(make_item(OP_ADD, 15, 6, 2023, 0));
    send_date(make_item(OP_SUB, 15, 6, 2023, 0));
    send_date(make_item(OP_ADD, 31, 1, 2023, 1));
    send_date(make_item(OP_ADD, 28, 2, 2000, 1));    // leap by the 400 rule
    send_date(make_item(OP_ADD, 28, 2, 1900, 1));    // century, not leap
    send_date(make_item(OP_ADD, 28, 2, 2024, 1));
    send_date(make_item(OP_ADD, 31, 12, 1999, 1));   // year carry
    send_date(make_item(OP_SUB, 1, 1, 2000, 1));     // year borrow
    send_date(make_item(OP_SUB, 1, 3, 2100, 1));
    send_date(make_item(OP_ADD, 1, 1, YEAR_MIN, 65535));
    send_date(make_item(OP_SUB, 31, 12, YEAR_MAX, 65535));
    send_date(make_item(OP_SUB, 1, 1, YEAR_MIN, 1)); // falls below range
    send_date(make_item(OP_ADD, 31, 12, YEAR_MAX, 1)); // goes above range
    send_date(make_item(OP_ADD, 0, 5, 2001, 10));    // day zero
    send_date(make_item(OP_SUB, 31, 2, 2023, 3));    // day past month end
    send_date(make_item(OP_ADD, 10, 0, 2010, 40));   // month zero
    send_date(make_item(OP_SUB, 10, 15, 2010, 40));  // month past december
    send_date(make_item(OP_ADD, 5, 5, 0, 100));      // start year below range
    send_date(make_item(OP_SUB, 31, 15, 16383, 100));
    send_date(make_item(OP_ADD, 31, 15, 16383, 65535));
    send_date(make_item(OP_SUB, 0, 0, 0, 65535));
    send_date(make_item(OP_ADD, 29, 2, 2024, 365));
    send_date(make_item(OP_SUB, 1, 3, 2000, 366));
  endtask

  // sender holds off until the unit has returned everything
  task automatic test_drained_sends();
    repeat (8) begin
      send_date(rand_valid_item());
      wait_drained();
    end
  endtask

  task automatic test_random_dates();
    repeat (170) send_date(rand_valid_item());
  endtask

  task automatic test_raw_fields();
    repeat (40) begin
      send_date(make_item(logic'($urandom_range(0, 1)), $urandom_range(0, 31),
                          $urandom_range(0, 15), $urandom_range(0, 16383),
                          $urandom_range(0, 65535)));
    end
  endtask

  task automatic test_back_to_back();
    wait_drained();
    idle_on = 1'b0;
    repeat (30) send_date(rand_valid_item());
  endtask

  // ---- result side ----
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  function automatic bit stall_pending();
    return ready_stall_left > 0;
  endfunction

  always @(posedge clk) begin
    if (idle_on && stall_pending()) begin
      ready_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_stall_left = $urandom_range(1, 18) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    date_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("result beat with nothing pending, day", int'(m_axis_tdata[4:0]), 0);
      end else begin
        want = pending_dates.pop_front();
        check_field("result_day", int'(m_axis_tdata[4:0]), int'(want.day));
        check_field("result_month", int'(m_axis_tdata[8:5]), int'(want.month));
        check_field("result_year", int'(m_axis_tdata[22:9]), int'(want.year));
        check_field("out_of_range", int'(m_axis_tuser[0]), int'(want.oor));
        results_checked++;
        if (want.oor) flagged_results++;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_calendar_corners();
    test_drained_sends();
    test_random_dates();
    test_raw_fields();
    test_back_to_back();
    wait_drained();
    repeat (64) @(posedge clk);
    if (pending_dates.size() != 0) report_mismatch("results never returned", 0,
                                                   pending_dates.size());
    $display("sent %0d date beats (add and subtract, calendar corners, raw fields)",
             items_sent);
    $display("checked %0d results, %0d of them flagged out of range",
             results_checked, flagged_results);
    if (error_count == 0) begin
      $display("[gregorian_date_offset_unit] OK");
    end else begin
      $display("[gregorian_date_offset_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout with %0d results outstanding", pending_dates.size());
    $display("[gregorian_date_offset_unit] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
src/gdo_pkg.sv
src/gdo_datapath.sv
src/gdo_ctrl.sv
src/gregorian_date_offset_unit.sv
src/gdo_checker.sv
tb/gregorian_date_offset_unit_test.sv
